@@ design/fir24_pkg.sv @@
// Shared types, constants and the microcode program of the 24-bit audio FIR filter.
package fir24_pkg;

  localparam int TAPS_DEF        = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SAMPLE_W        = 24;
  localparam int COEF_W          = 24;
  localparam int IDX_W           = 6;
  localparam int COEF_FRAC       = 23;

  // Request codes on the input channel.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // Sequencer step codes.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_MAC    = 3'd1;
  localparam logic [STEP_W-1:0] ST_DRAIN0 = 3'd2;
  localparam logic [STEP_W-1:0] ST_DRAIN1 = 3'd3;
  localparam logic [STEP_W-1:0] ST_WAIT   = 3'd4;
  localparam logic [STEP_W-1:0] ST_ROUND  = 3'd5;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_NOT_SAMPLE,
    CND_NOT_LAST,
    CND_OUT_BUSY
  } cond_e;

  // Datapath controls of one step.
  typedef struct packed {
    logic accept;
    logic clr_acc;
    logic issue;
    logic round;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic last_tap;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    ctrl_t               ctrl;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
  } uword_t;

  // The control program, one word per step.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w        = '0;
    w.cond   = CND_NEXT;
    w.target = ST_IDLE;
    case (step)
      ST_IDLE: begin
        w.ctrl.accept  = 1'b1;
        w.ctrl.clr_acc = 1'b1;
        w.cond         = CND_NOT_SAMPLE;
        w.target       = ST_IDLE;
      end
      ST_MAC: begin
        w.ctrl.issue = 1'b1;
        w.cond       = CND_NOT_LAST;
        w.target     = ST_MAC;
      end
      ST_DRAIN0: w.cond = CND_NEXT;
      ST_DRAIN1: w.cond = CND_NEXT;
      ST_WAIT: begin
        w.cond   = CND_OUT_BUSY;
        w.target = ST_WAIT;
      end
      ST_ROUND: begin
        w.ctrl.round = 1'b1;
        w.cond       = CND_ALWAYS;
        w.target     = ST_IDLE;
      end
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/fir24_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fir24_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fir24_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module fir24_seq import fir24_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  req_type_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            word;
  logic              sample_acc;

  assign word       = ucode(step_q);
  assign ctrl_o     = word.ctrl;
  assign sample_acc = word.ctrl.accept && in_valid_i && (req_type_i == REQ_SAMPLE);

  always_comb begin
    case (word.cond)
      CND_NEXT:       step_d = step_q + 1'b1;
      CND_ALWAYS:     step_d = word.target;
      CND_NOT_SAMPLE: step_d = sample_acc ? step_q + 1'b1 : word.target;
      CND_NOT_LAST:   step_d = stat_i.last_tap ? step_q + 1'b1 : word.target;
      CND_OUT_BUSY:   step_d = stat_i.out_busy ? word.target : step_q + 1'b1;
      default:        step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ design/fir24_dp.sv @@
// Datapath: history ring, tap table, shared multiply-accumulate and output register.
module fir24_dp import fir24_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  output stat_t                    stat_o,
  input  logic                     in_valid_i,
  input  logic                     req_type_i,
  input  logic [SAMPLE_W-1:0]      sample_in_i,
  input  logic [IDX_W-1:0]         coeff_index_i,
  input  logic signed [COEF_W-1:0] coeff_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SAMPLE_W-1:0]      sample_out_o
);

  localparam int AW       = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW       = $clog2(TAPS + 1);
  localparam int PW       = SAMPLE_BITS + COEF_W;
  localparam int ACC_FULL = PW + AW + 1;
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam logic [63:0] OUT_MASK64 =
    (SAMPLE_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [31:0] OUT_MASK = OUT_MASK64[31:0];
  localparam logic [63:0] RND_BIAS = (64'd1 << COEF_FRAC) - 64'd1;

  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] tap_q, tap_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          rd_v_q, mul_v_q, hv_q;
  logic          out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_q, out_d;
  logic signed [PW-1:0]    prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic                   sample_acc, load_acc, idx_ok;
  logic [31:0]            raw_ext, idx_ext;
  logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;
  logic [COEF_W-1:0]      coef_rdata;
  logic signed [SAMPLE_BITS-1:0] hist_s;
  logic [63:0]            acc64, sum64;
  logic [31:0]            res32;

  assign raw_ext    = 32'(sample_in_i);
  assign hist_wdata = raw_ext[SAMPLE_BITS-1:0];
  assign idx_ext    = 32'(coeff_index_i);
  assign idx_ok     = idx_ext < 32'(TAPS);
  assign sample_acc = ctrl_i.accept && in_valid_i && (req_type_i == REQ_SAMPLE);
  assign load_acc   = ctrl_i.accept && in_valid_i && (req_type_i == REQ_LOAD);

  fir24_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (sample_acc),
    .waddr_i (pos_q),
    .wdata_i (hist_wdata),
    .raddr_i (rp_q),
    .rdata_o (hist_rdata)
  );

  fir24_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_taps (
    .clk_i   (clk_i),
    .we_i    (load_acc && idx_ok),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (coeff_value_i),
    .raddr_i (tap_q),
    .rdata_o (coef_rdata)
  );

  // Ring pointers and the fill count that masks history never written since reset.
  always_comb begin
    pos_d  = pos_q;
    rp_d   = rp_q;
    tap_d  = tap_q;
    fill_d = fill_q;
    if (sample_acc) begin
      pos_d = (pos_q == AW'(TAPS - 1)) ? '0 : pos_q + 1'b1;
      rp_d  = pos_q;
      tap_d = '0;
      if (fill_q != FW'(TAPS)) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (ctrl_i.issue) begin
      rp_d  = (rp_q == '0) ? AW'(TAPS - 1) : rp_q - 1'b1;
      tap_d = tap_q + 1'b1;
    end
  end

  assign hist_s = hv_q ? signed'(hist_rdata) : '0;
  assign prod_d = hist_s * signed'(coef_rdata);
  assign acc_d  = ctrl_i.clr_acc ? '0 : (mul_v_q ? acc_q + ACC_W'(prod_q) : acc_q);

  // Truncation toward zero: bias negative sums before dropping the fraction bits.
  assign acc64 = 64'(acc_q);
  assign sum64 = acc64 + (acc64[63] ? RND_BIAS : 64'd0);
  assign res32 = sum64[COEF_FRAC+31:COEF_FRAC] & OUT_MASK;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ctrl_i.round) begin
      out_valid_d = 1'b1;
      out_d       = res32[SAMPLE_W-1:0];
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rp_q        <= '0;
      tap_q       <= '0;
      fill_q      <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      hv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      rp_q        <= rp_d;
      tap_q       <= tap_d;
      fill_q      <= fill_d;
      rd_v_q      <= ctrl_i.issue;
      mul_v_q     <= rd_v_q;
      hv_q        <= 32'(rp_q) < 32'(fill_q);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign stat_o.last_tap = (tap_q == AW'(TAPS - 1));
  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;

endmodule

@@ design/fir_filter_24bit_audio.sv @@
// Top level of the direct-form FIR filter for 24-bit audio samples.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  req_type_i, sample_in_i, coeff_index_i,
//                                              coeff_value_i
//   out      output     out_valid_o/out_stall_i sample_out_o
//
// A coefficient-load beat is taken in the idle step and gives no result. A sample beat
// passes through these steps before the next beat is taken: the idle step that takes
// the beat, one tap per cycle on the single multiply-accumulate unit and the one read
// port of the history RAM, the drain steps that empty the pipeline, a wait step that
// holds while the result register is still stalled, and the rounding step that writes it.
// After reset the history reads as zero through a fill count, so there is no clearing
// pass; the tap table is undefined until it is loaded.
// While out_stall_i holds a finished result, the next sample is still accepted and
// computed; the sequencer waits only before writing the new result.
module fir_filter_24bit_audio import fir24_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [SAMPLE_W-1:0]      sample_in_i,
  input  logic [IDX_W-1:0]         coeff_index_i,
  input  logic signed [COEF_W-1:0] coeff_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SAMPLE_W-1:0]      sample_out_o
);

  ctrl_t ctrl;
  stat_t stat;

  // The sequencer steps through its program and drives the datapath one word per cycle.
  fir24_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Input beats are taken only in the idle step of the program.
  assign in_stall_o = !ctrl.accept;

  // The datapath holds both RAMs, the multiply-accumulate pipeline and the result register.
  fir24_dp #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_valid_i    (in_valid_i),
    .req_type_i    (req_type_i),
    .sample_in_i   (sample_in_i),
    .coeff_index_i (coeff_index_i),
    .coeff_value_i (coeff_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o)
  );

endmodule
